@@ rtl/assert_macros.svh @@
// Assertion macros for the checker RTL, used by its segment parser.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the clock and disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/qchk_pkg.sv @@
// Package for the dotted-quad checker: character codes, limits and types.
// Depends on nothing; imported by every RTL module of the block.
package qchk_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned SegValW  = 9;
  localparam int unsigned SegCntW  = 3;
  localparam int unsigned ProductW = 12;

  localparam logic [CharW-1:0]   CharNul  = 8'h00;
  localparam logic [CharW-1:0]   CharDot  = 8'h2E;
  localparam logic [CharW-1:0]   CharZero = 8'h30;
  localparam logic [CharW-1:0]   CharNine = 8'h39;

  localparam logic [SegValW-1:0] MaxOctet     = 9'd255;
  localparam logic [SegValW-1:0] ValueCap     = 9'd256;
  localparam logic [SegCntW-1:0] WantSegments = 3'd4;
  localparam logic [SegCntW-1:0] CountCap     = 3'd5;

  typedef struct packed {
    logic               is_ipv4;
    logic [SegCntW-1:0] segment_count;
  } verdict_t;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

endpackage

@@ rtl/qchk_in_stage.sv @@
// Input register of the dotted-quad checker: holds one byte beat and its valid.
// Depends on qchk_pkg.
module qchk_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [qchk_pkg::CharW-1:0] char_code_i,
  input  logic                      take_i,
  output logic                      valid_o,
  output logic [qchk_pkg::CharW-1:0] char_o
);
  import qchk_pkg::*;

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;
  logic             load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_code_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

endmodule

@@ rtl/qchk_parse.sv @@
// Segment parser of the dotted-quad checker: string state and its per-byte update.
// Depends on qchk_pkg and assert_macros.svh.
module qchk_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [qchk_pkg::CharW-1:0] char_i,
  output qchk_pkg::verdict_t         verdict_o
);
  import qchk_pkg::*;

  logic [SegCntW-1:0]  cnt_q, cnt_d;
  logic                in_seg_q, in_seg_d;
  logic                run_q, run_d;
  logic [SegValW-1:0]  val_q, val_d;
  logic                fail_q, fail_d;
  logic                is_nul, is_sep, digit, over;
  logic [3:0]          dig_val;
  logic [CharW-1:0]    offset;
  logic [ProductW-1:0] product;

  assign is_nul  = (char_i == CharNul);
  assign is_sep  = is_nul || (char_i == CharDot);
  assign digit   = is_digit(char_i);
  assign offset  = char_i - CharZero;
  assign dig_val = offset[3:0];
  assign product = {{(ProductW-SegValW){1'b0}}, val_q} * ProductW'(10)
                 + {{(ProductW-4){1'b0}}, dig_val};
  assign over    = in_seg_q && (val_q > MaxOctet);

  always_comb begin
    cnt_d    = cnt_q;
    in_seg_d = in_seg_q;
    run_d    = run_q;
    val_d    = val_q;
    fail_d   = fail_q;
    if (go_i) begin
      if (is_sep) begin
        if (over) begin
          fail_d = 1'b1;
        end
        in_seg_d = 1'b0;
        run_d    = 1'b0;
        val_d    = '0;
        if (is_nul) begin
          cnt_d  = '0;
          fail_d = 1'b0;
        end
      end else if (!in_seg_q) begin
        in_seg_d = 1'b1;
        if (cnt_q < CountCap) begin
          cnt_d = cnt_q + SegCntW'(1);
        end
        if (digit) begin
          run_d = 1'b1;
          val_d = {{(SegValW-4){1'b0}}, dig_val};
        end else begin
          run_d  = 1'b0;
          fail_d = 1'b1;
        end
      end else if (run_q) begin
        if (digit) begin
          val_d = (product > {{(ProductW-SegValW){1'b0}}, ValueCap}) ?
                  ValueCap : product[SegValW-1:0];
        end else begin
          run_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      in_seg_q <= 1'b0;
      run_q    <= 1'b0;
      val_q    <= '0;
      fail_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      in_seg_q <= in_seg_d;
      run_q    <= run_d;
      val_q    <= val_d;
      fail_q   <= fail_d;
    end
  end

  always_comb begin
    verdict_o.is_ipv4       = !(fail_q || over) && (cnt_q == WantSegments);
    verdict_o.segment_count = cnt_q;
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_cnt_cap, clk_i, rst_ni, cnt_q <= CountCap, "segment count passed its cap")
  `ASSERT_CLK(a_val_cap, clk_i, rst_ni, val_q <= ValueCap, "segment value passed its cap")
  `ASSERT_CLK(a_run_in_seg, clk_i, rst_ni, !run_q || in_seg_q, "digit run outside a segment")
  `ASSERT_CLK(a_nul_clears, clk_i, rst_ni, (go_i && is_nul) |=> (cnt_q == '0 && !fail_q && !in_seg_q), "state not cleared after NUL")

endmodule

@@ rtl/ipv4_dotted_quad_checker.sv @@
// Dotted IPv4 address checker for a byte stream.
// Byte channel: in_valid_i, in_stall_o, char_code_i; one beat is one character.
// Result channel: out_valid_o, out_stall_i, is_ipv4_o, segment_count_o.
// A string ends with a NUL byte, and only the NUL beat yields a result beat:
// is_ipv4_o is set for exactly four segments, each led by digits of at most 255,
// and segment_count_o gives the non-empty segments seen, saturating at five.
// Throughput is one byte per cycle unless a NUL waits in the input register;
// the per-byte update is a short path from the input register through the
// parser into the state and result registers, as is a NUL beat's verdict.
// While the receiver stalls a pending result, ordinary bytes keep flowing and
// only the next NUL waits in the input register, which then stalls the sender.
// Reset clears the string state and both valid flags; no result is pending.
// Depends on qchk_pkg, qchk_in_stage and qchk_parse.
module ipv4_dotted_quad_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [qchk_pkg::CharW-1:0]   char_code_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         is_ipv4_o,
  output logic [qchk_pkg::SegCntW-1:0] segment_count_o
);
  import qchk_pkg::*;

  logic             s1_valid, s1_go, out_free, s1_nul;
  logic [CharW-1:0] s1_char;
  verdict_t         verdict;
  verdict_t         res_q;
  logic             out_valid_q, out_valid_d;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_nul   = (s1_char == CharNul);
  assign s1_go    = s1_valid && (!s1_nul || out_free);

  qchk_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_code_i(char_code_i),
    .take_i     (s1_go),
    .valid_o    (s1_valid),
    .char_o     (s1_char)
  );

  qchk_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (s1_go),
    .char_i   (s1_char),
    .verdict_o(verdict)
  );

  assign out_valid_d = (s1_go && s1_nul) ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_nul) begin
      res_q <= verdict;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_ipv4_o       = res_q.is_ipv4;
  assign segment_count_o = res_q.segment_count;

endmodule

@@ tb/sv/qchk_scoreboard.sv @@
// Checker for the dotted-quad checker: watches both channels, predicts each verdict
// from the accepted bytes and compares it with the result beats. Depends on qchk_pkg.
module qchk_scoreboard (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [qchk_pkg::CharW-1:0]   char_code_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         is_ipv4_i,
  input  logic [qchk_pkg::SegCntW-1:0] segment_count_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  verdicts_o,
  output int unsigned                  passed_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qchk_pkg::*;

  logic [SegCntW-1:0] segs;
  logic               seg_open;
  logic               in_digits;
  logic [SegValW-1:0] seg_val;
  logic               broken;
  verdict_t           verdicts_due[$];

  task automatic take_char(input logic [CharW-1:0] c);
    int unsigned grown;
    verdict_t    v;
    if (c == CharNul || c == CharDot) begin
      if (seg_open && seg_val > MaxOctet) broken = 1'b1;
      seg_open  = 1'b0;
      in_digits = 1'b0;
      seg_val   = '0;
      if (c == CharNul) begin
        v.is_ipv4       = !broken && (segs == WantSegments);
        v.segment_count = segs;
        verdicts_due.push_back(v);
        segs   = '0;
        broken = 1'b0;
      end
    end else if (!seg_open) begin
      seg_open = 1'b1;
      if (segs < CountCap) segs = segs + 1'b1;
      if (c >= CharZero && c <= CharNine) begin
        in_digits = 1'b1;
        seg_val   = SegValW'(c - CharZero);
      end else begin
        in_digits = 1'b0;
        broken    = 1'b1;
      end
    end else if (in_digits) begin
      if (c >= CharZero && c <= CharNine) begin
        grown   = seg_val * 10 + (c - CharZero);
        seg_val = (grown > ValueCap) ? ValueCap : grown[SegValW-1:0];
      end else begin
        in_digits = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      segs         = '0;
      seg_open     = 1'b0;
      in_digits    = 1'b0;
      seg_val      = '0;
      broken       = 1'b0;
      verdicts_due.delete();
      fail_count_o = 0;
      verdicts_o   = 0;
      passed_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          $error("Result beat arrived with no verdict pending.");
          fail_count_o++;
        end else begin
          want = verdicts_due.pop_front();
          verdicts_o++;
          if (want.is_ipv4) passed_o++;
          if (is_ipv4_i !== want.is_ipv4) begin
            $error("is_ipv4: expected %0d, actual %0d", want.is_ipv4, is_ipv4_i);
            fail_count_o++;
          end
          if (segment_count_i !== want.segment_count) begin
            $error("segment_count: expected %0d, actual %0d",
                   want.segment_count, segment_count_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_char(char_code_i);
    end
    pending_o = verdicts_due.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the dotted-quad checker: clock, reset, byte strings and result stalls.
// Depends on qchk_pkg, the block under test and the qchk_scoreboard checker.
module tb;
  import qchk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteTarget = 950;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned IdleLimit  = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [CharW-1:0]   char_code_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               is_ipv4_o;
  logic [SegCntW-1:0] segment_count_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned verdicts;
  int unsigned passed;
  int unsigned bytes_sent;
  int unsigned strings_sent;
  int unsigned idle_cycles;
  logic [CharW-1:0] text[$];

  ipv4_dotted_quad_checker dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .char_code_i,
    .out_valid_o, .out_stall_i, .is_ipv4_o, .segment_count_o
  );

  qchk_scoreboard scoreboard (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .char_code_i,
    .out_valid_i(out_valid_o), .out_stall_i, .is_ipv4_i(is_ipv4_o),
    .segment_count_i(segment_count_o), .fail_count_o(fail_count),
    .pending_o(pending), .verdicts_o(verdicts), .passed_o(passed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("status: fail");
          $finish;
        end
      end
    end else begin
      idle_cycles = 0;
    end
  end

  initial begin
    bit          held;
    bit          run_stall;
    int unsigned run_left;
    held        = 1'b0;
    run_left    = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && verdicts >= 20) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 3) == 0);
          if (!run_stall) run_left = $urandom_range(1, 20);
          else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(10, 30);
          else run_left = $urandom_range(1, 3);
        end
        out_stall_i <= run_stall;
        run_left--;
      end
    end
  end

  task automatic queue_text(input string s);
    foreach (s[i]) text.push_back(s[i]);
    text.push_back(CharNul);
  endtask

  task automatic send_text();
    int unsigned gap;
    int unsigned r;
    bit          burst;
    burst = ($urandom_range(0, 3) == 0);
    foreach (text[i]) begin
      r = $urandom_range(0, 99);
      if (burst || r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 8);
      else gap = $urandom_range(15, 40);
      if (gap > 0) begin
        in_valid_i  <= 1'b0;
        char_code_i <= CharW'($urandom_range(0, 255));
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i  <= 1'b1;
      char_code_i <= text[i];
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      @(negedge clk_i);
      bytes_sent++;
    end
    strings_sent++;
    text = {};
  endtask

  initial begin
    int unsigned nseg;
    int unsigned kind;
    int unsigned len;
    int unsigned val;
    logic [CharW-1:0] b;
    string digits;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    char_code_i  = '0;
    bytes_sent   = 0;
    strings_sent = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    text = {CharNul};
    send_text();
    text = {CharDot, 8'hFF, CharNul};
    send_text();
    queue_text("255..0.9x.7");
    send_text();
    queue_text("999.1.2.3.4.5");
    send_text();

    while (bytes_sent < ByteTarget) begin
      if ($urandom_range(0, 9) < 7) begin
        nseg = ($urandom_range(0, 4) != 0) ? 4 : $urandom_range(1, 7);
        if ($urandom_range(0, 9) == 0) text.push_back(CharDot);
        for (int s = 0; s < nseg; s++) begin
          if (s > 0) begin
            text.push_back(CharDot);
            if ($urandom_range(0, 7) == 0) text.push_back(CharDot);
          end
          kind = $urandom_range(0, 19);
          if (kind == 19) begin
            if ($urandom_range(0, 1) == 0) begin
              text.push_back(CharW'($urandom_range(1, CharDot - 1)));
            end else begin
              text.push_back(CharW'($urandom_range(CharNine + 1, 255)));
            end
          end else begin
            if (kind == 0) val = $urandom_range(256, 999);
            else if (kind == 1) val = 255;
            else if (kind == 2) val = 0;
            else if (kind == 3) val = $urandom_range(1000, 99999);
            else val = $urandom_range(0, 255);
            if ($urandom_range(0, 9) == 0) text.push_back(CharZero);
            digits = $sformatf("%0d", val);
            foreach (digits[i]) text.push_back(digits[i]);
          end
          if ($urandom_range(0, 14) == 0) begin
            b = CharW'($urandom_range(1, 254));
            if (b >= CharDot) b = b + 1'b1;
            text.push_back(b);
          end
        end
        if ($urandom_range(0, 9) == 0) text.push_back(CharDot);
      end else begin
        len = $urandom_range(0, 12);
        repeat (len) begin
          kind = $urandom_range(0, 3);
          if (kind == 0) text.push_back(CharDot);
          else if (kind == 1) text.push_back(CharW'($urandom_range(CharZero, CharNine)));
          else text.push_back(CharW'($urandom_range(1, 255)));
        end
      end
      text.push_back(CharNul);
      send_text();
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings, including empty, dot-only and overlong ones.",
             bytes_sent, strings_sent);
    $display("Checked %0d verdicts, %0d of them valid addresses.", verdicts, passed);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/qchk_pkg.sv
rtl/qchk_in_stage.sv
rtl/qchk_parse.sv
rtl/ipv4_dotted_quad_checker.sv
tb/sv/qchk_scoreboard.sv
tb/sv/tb.sv
